[rtl/mlfqs_priority_engine_defines.svh]
// Assertion macros for the priority engine.
`ifndef MLFQS_PRIORITY_ENGINE_DEFINES_SVH
`define MLFQS_PRIORITY_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define MLFQS_ASSERT_IMP(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("mlfqs: same-cycle check failed");
`define MLFQS_ASSERT_NXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("mlfqs: next-cycle check failed");
`else
`define MLFQS_ASSERT_IMP(lbl, ck, rn, a, c)
`define MLFQS_ASSERT_NXT(lbl, ck, rn, a, c)
`endif
`endif

[rtl/mlfqs_pkg.sv]
// Shared types and constants of the priority engine.
package mlfqs_pkg;

	localparam int FRAC_BITS = 14;
	localparam int FP_ONE = 16384;
	localparam int FP_HALF = 8192;
	localparam int PRI_SHIFT = 16;
	localparam int LA_DECAY = 59 * FP_ONE / 60;
	localparam int LA_GAIN = FP_ONE / 60;
	localparam int X100 = 100;
	localparam int LA_X100_MAX = 6400;
	localparam int NICE_LIM = 20;

	localparam int DIV_NW = 47;
	localparam int DIV_DW = 33;
	localparam int DIV_CW = 6;
	localparam int COEF_W = 15;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_NICE   = 3'd1,
		CMD_CREATE = 3'd2,
		CMD_EXIT   = 3'd3,
		CMD_READY  = 3'd4,
		CMD_SWITCH = 3'd5
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP, ST_CHG_RD, ST_CHG_WR, ST_CNT, ST_LA_MUL, ST_LA_ADD,
		ST_DIV_GO, ST_DIV_WAIT, ST_RC_SCAN, ST_PRI_SCAN, ST_RUN_RD, ST_RUN_GET,
		ST_OUT_SCAN, ST_NICE_RD, ST_NICE_WR, ST_NEW_RD, ST_NEW_WR, ST_REP_RD,
		ST_REP_GET, ST_REP_RC, ST_REP_LA, ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[rtl/mlfqs_req_if.sv]
// Command channel of the priority engine.
interface mlfqs_req_if ();
	logic              valid;
	logic              ready;
	logic [2:0]        cmd;
	logic [5:0]        thread_slot;
	logic              running_idle;
	logic signed [5:0] nice_value;
	logic [5:0]        parent_slot;
	logic              flag_value;

	modport source (output valid, cmd, thread_slot, running_idle, nice_value, parent_slot,
		flag_value, input ready);
	modport sink (input valid, cmd, thread_slot, running_idle, nice_value, parent_slot,
		flag_value, output ready);
endinterface

[rtl/mlfqs_rsp_if.sv]
// Result channel of the priority engine.
interface mlfqs_rsp_if ();
	logic               valid;
	logic               ready;
	logic               yield_now;
	logic [5:0]         slot_priority;
	logic signed [25:0] recent_cpu_x100;
	logic [12:0]        load_avg_x100;

	modport source (output valid, yield_now, slot_priority, recent_cpu_x100, load_avg_x100,
		input ready);
	modport sink (input valid, yield_now, slot_priority, recent_cpu_x100, load_avg_x100,
		output ready);
endinterface

[rtl/mlfqs_mul.sv]
// Shared signed multiplier with registered product.
module mlfqs_mul (
	input  logic               clk,
	input  logic signed [31:0] op_a,
	input  logic signed [15:0] op_b,
	output logic signed [47:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= 48'(op_a) * 48'(op_b);
	end

endmodule

[rtl/mlfqs_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module mlfqs_div import mlfqs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic [DIV_NW-1:0] quo,
	output div_stat_t         stat
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CW'(DIV_NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : DIV_DW'(trial);
			num_q <= {num_q[DIV_NW-2:0], fits};
		end
	end

	assign quo = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/mlfqs_priority_engine.sv]
// Multilevel feedback priority engine, 17.14 fixed point, top level.
//
// Usage: commands arrive one beat at a time on req (valid/ready); each command
// gives exactly one beat on rsp holding the yield request, the addressed slot's
// priority and cpu usage x100, and the load average x100.
// The engine works on one command at a time; req.ready is high only while idle.
// Extra work per command: a tick that charges the running slot adds a charge
// step; every fourth tick adds a priority pass and outrank scan (with a read of
// the running slot's priority when a thread is running); set nice adds an
// outrank scan; a second boundary adds a ready count, load update, a 47-step
// divide and a cpu usage pass. The table memory read port and the shared
// multiplier handle one slot per cycle in every pass.
// Reset clears the valid and ready marks, load average and tick counters; the
// table memories are not cleared and must be written by create first.
// A finished result waits in the output register while rsp.ready is low; the
// engine takes the next command then, but does not finish it until the output
// register is free.
`include "mlfqs_priority_engine_defines.svh"
module mlfqs_priority_engine import mlfqs_pkg::*; #(
	parameter int NUM_THREADS = 64,
	parameter int PRI_TOP = 63,
	parameter int TICKS_PER_SECOND = 100,
	parameter int SLICE_TICKS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	mlfqs_req_if.sink  req,
	mlfqs_rsp_if.source rsp
);

	localparam int IW = $clog2(NUM_THREADS);
	localparam int SW = IW + 6;
	localparam int CW = $clog2(NUM_THREADS + 3);
	localparam int RW = $clog2(NUM_THREADS + 2);
	localparam int PW = $clog2(PRI_TOP + 1);
	localparam int PHW = $clog2(TICKS_PER_SECOND);
	localparam int SLW = $clog2(SLICE_TICKS + 1);

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -48'sh0000_8000_0000) return -32'sh8000_0000;
		return 32'(v);
	endfunction

	function automatic logic signed [47:0] trunc_fp(input logic signed [47:0] v);
		return (v + (v[47] ? 48'(FP_ONE - 1) : 48'sd0)) >>> FRAC_BITS;
	endfunction

	function automatic logic signed [47:0] round_fp(input logic signed [47:0] v);
		if (v[47]) return -((-v + 48'(FP_HALF)) >>> FRAC_BITS);
		return (v + 48'(FP_HALF)) >>> FRAC_BITS;
	endfunction

	function automatic logic [PW-1:0] calc_pri(input logic signed [31:0] rc,
		input logic signed [5:0] nv);
		logic signed [31:0] q;
		logic signed [19:0] p;
		q = (rc + (rc[31] ? 32'((1 << PRI_SHIFT) - 1) : 32'sd0)) >>> PRI_SHIFT;
		p = 20'(PRI_TOP) - 20'(q) - (20'(nv) <<< 1);
		if (p > 20'(PRI_TOP)) p = 20'(PRI_TOP);
		if (p < 20'sd0) p = 20'sd0;
		return PW'(p);
	endfunction

	state_t state_q, state_d;

	logic [2:0]        cmd_q;
	logic [5:0]        slot_q;
	logic [5:0]        parent_q;
	logic              idle_q;
	logic              flag_q;
	logic signed [5:0] nice_q;
	logic signed [5:0] nice_in;

	logic [NUM_THREADS-1:0] valid_q;
	logic [NUM_THREADS-1:0] ready_q;

	logic signed [5:0]  nice_mem [NUM_THREADS];
	logic signed [31:0] rc_mem [NUM_THREADS];
	logic [PW-1:0]      pri_mem [NUM_THREADS];
	logic signed [5:0]  rd_nice_q;
	logic signed [31:0] rd_rc_q;
	logic [PW-1:0]      rd_pri_q;

	logic [IW-1:0]      raddr, waddr;
	logic               we_nice, we_rc, we_pri;
	logic signed [5:0]  wd_nice;
	logic signed [31:0] wd_rc;
	logic [PW-1:0]      wd_pri;

	logic signed [31:0] la_q;
	logic [PHW-1:0]     sec_q;
	logic [1:0]         qtr_q;
	logic [SLW-1:0]     slc_q, slc_next;
	logic               sec_hit_d, qtr_hit_d, sec_hit_q, qtr_hit_q;

	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     scan_idx, idx_s1, idx_s2;
	logic signed [5:0] nice_s2;
	logic [RW-1:0]     rcnt_q;
	logic [COEF_W-1:0] coef_q;
	logic [PW-1:0]     run_pri_q;
	logic              yld_q;

	logic [PW-1:0]      res_pri_q;
	logic signed [25:0] res_rc_q;
	logic [12:0]        res_la_q;

	logic               rsp_valid_q;
	logic               out_yield_q;
	logic [5:0]         out_pri_q;
	logic signed [25:0] out_rc_q;
	logic [12:0]        out_la_q;
	logic               out_free;

	logic [SW-1:0] slot_w, par_w;
	logic [IW-1:0] slot_idx, par_idx;
	logic          slot_in, par_in, slot_vld, run_ok, inherit;
	logic [PW+5:0] pri_w;

	logic signed [31:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [47:0] prod_s1;
	logic signed [47:0] gain_w;
	logic signed [47:0] la_r;

	logic              div_go;
	logic [DIV_NW-1:0] div_quo;
	div_stat_t         div_st;

	mlfqs_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_s1(prod_s1)
	);

	mlfqs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_go),
		.num   ({la_q, 15'd0}),
		.den   ({la_q, 1'b0} + DIV_DW'(FP_ONE)),
		.quo   (div_quo),
		.stat  (div_st)
	);

	assign slot_w = SW'(slot_q);
	assign par_w = SW'(parent_q);
	assign slot_idx = slot_w[IW-1:0];
	assign par_idx = par_w[IW-1:0];
	assign slot_in = slot_w < SW'(NUM_THREADS);
	assign par_in = par_w < SW'(NUM_THREADS);
	assign slot_vld = slot_in && valid_q[slot_idx];
	assign run_ok = !idle_q && slot_in;
	assign inherit = flag_q && par_in;
	assign scan_idx = cnt_q[IW-1:0];
	assign out_free = !rsp_valid_q || rsp.ready;

	assign sec_hit_d = (32'(sec_q) + 32'd1) >= 32'(TICKS_PER_SECOND);
	assign qtr_hit_d = qtr_q == 2'd3;
	assign slc_next = (32'(slc_q) < 32'(SLICE_TICKS)) ? slc_q + SLW'(1) : slc_q;
	assign gain_w = 48'(rcnt_q) * 48'(LA_GAIN);
	assign la_r = round_fp(prod_s1);

	always_comb begin
		if (req.nice_value > 6'sd20) nice_in = 6'(NICE_LIM);
		else if (req.nice_value < -6'sd20) nice_in = -6'(NICE_LIM);
		else nice_in = req.nice_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		raddr = slot_idx;
		waddr = slot_idx;
		we_nice = 1'b0;
		we_rc = 1'b0;
		we_pri = 1'b0;
		wd_nice = nice_q;
		wd_rc = rd_rc_q;
		wd_pri = calc_pri(rd_rc_q, rd_nice_q);
		mul_a = '0;
		mul_b = '0;
		div_go = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_DISP;
			end
			ST_DISP: begin
				unique case (cmd_q)
					CMD_TICK: begin
						if (!idle_q && slot_vld) state_d = ST_CHG_RD;
						else if (sec_hit_d) state_d = ST_CNT;
						else if (qtr_hit_d) state_d = ST_PRI_SCAN;
						else state_d = ST_REP_RD;
					end
					CMD_NICE: state_d = slot_vld ? ST_NICE_RD : ST_REP_RD;
					CMD_CREATE: state_d = slot_in ? ST_NEW_RD : ST_REP_RD;
					default: state_d = ST_REP_RD;
				endcase
			end
			ST_CHG_RD: state_d = ST_CHG_WR;
			ST_CHG_WR: begin
				we_rc = 1'b1;
				wd_rc = sat32(48'(rd_rc_q) + 48'(FP_ONE));
				if (sec_hit_q) state_d = ST_CNT;
				else if (qtr_hit_q) state_d = ST_PRI_SCAN;
				else state_d = ST_REP_RD;
			end
			ST_CNT: begin
				if (cnt_q == CW'(NUM_THREADS - 1)) state_d = ST_LA_MUL;
			end
			ST_LA_MUL: begin
				mul_a = la_q;
				mul_b = 16'(LA_DECAY);
				state_d = ST_LA_ADD;
			end
			ST_LA_ADD: state_d = ST_DIV_GO;
			ST_DIV_GO: begin
				if (la_q <= -32'sd8192) begin
					state_d = qtr_hit_q ? ST_PRI_SCAN : ST_REP_RD;
				end else begin
					div_go = 1'b1;
					state_d = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (div_st.done) state_d = ST_RC_SCAN;
			end
			ST_RC_SCAN: begin
				raddr = scan_idx;
				if (cnt_q >= CW'(1) && cnt_q <= CW'(NUM_THREADS)) begin
					mul_a = rd_rc_q;
					mul_b = 16'(coef_q);
				end
				if (cnt_q >= CW'(2)) begin
					waddr = idx_s2;
					we_rc = valid_q[idx_s2];
					wd_rc = sat32(trunc_fp(prod_s1) + (48'(nice_s2) <<< FRAC_BITS));
				end
				if (cnt_q == CW'(NUM_THREADS + 1)) state_d = qtr_hit_q ? ST_PRI_SCAN : ST_REP_RD;
			end
			ST_PRI_SCAN: begin
				raddr = scan_idx;
				if (cnt_q >= CW'(1)) begin
					waddr = idx_s1;
					we_pri = valid_q[idx_s1];
				end
				if (cnt_q == CW'(NUM_THREADS)) state_d = run_ok ? ST_RUN_RD : ST_OUT_SCAN;
			end
			ST_RUN_RD: state_d = ST_RUN_GET;
			ST_RUN_GET: state_d = ST_OUT_SCAN;
			ST_OUT_SCAN: begin
				raddr = scan_idx;
				if (cnt_q == CW'(NUM_THREADS)) state_d = ST_REP_RD;
			end
			ST_NICE_RD: begin
				we_nice = 1'b1;
				state_d = ST_NICE_WR;
			end
			ST_NICE_WR: begin
				we_pri = 1'b1;
				wd_pri = calc_pri(rd_rc_q, nice_q);
				state_d = ST_OUT_SCAN;
			end
			ST_NEW_RD: begin
				raddr = par_idx;
				state_d = ST_NEW_WR;
			end
			ST_NEW_WR: begin
				we_nice = 1'b1;
				we_rc = 1'b1;
				we_pri = 1'b1;
				wd_nice = inherit ? rd_nice_q : 6'sd0;
				wd_rc = inherit ? rd_rc_q : 32'sd0;
				wd_pri = calc_pri(inherit ? rd_rc_q : 32'sd0, inherit ? rd_nice_q : 6'sd0);
				state_d = ST_REP_RD;
			end
			ST_REP_RD: state_d = ST_REP_GET;
			ST_REP_GET: begin
				mul_a = slot_in ? rd_rc_q : 32'sd0;
				mul_b = 16'(X100);
				state_d = ST_REP_RC;
			end
			ST_REP_RC: begin
				mul_a = la_q;
				mul_b = 16'(X100);
				state_d = ST_REP_LA;
			end
			ST_REP_LA: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_nice_q <= nice_mem[raddr];
		rd_rc_q <= rc_mem[raddr];
		rd_pri_q <= pri_mem[raddr];
		if (we_nice) nice_mem[waddr] <= wd_nice;
		if (we_rc) rc_mem[waddr] <= wd_rc;
		if (we_pri) pri_mem[waddr] <= wd_pri;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			valid_q <= '0;
			ready_q <= '0;
			la_q <= '0;
			sec_q <= '0;
			qtr_q <= '0;
			slc_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= (state_d != state_q) ? '0 : cnt_q + CW'(1);
			if (state_q == ST_DISP) begin
				case (cmd_q)
					CMD_TICK: begin
						sec_q <= sec_hit_d ? '0 : sec_q + PHW'(1);
						qtr_q <= qtr_q + 2'd1;
						slc_q <= slc_next;
					end
					CMD_EXIT: begin
						if (slot_in) begin
							valid_q[slot_idx] <= 1'b0;
							ready_q[slot_idx] <= 1'b0;
						end
					end
					CMD_READY: begin
						if (slot_in) ready_q[slot_idx] <= flag_q;
					end
					CMD_SWITCH: slc_q <= '0;
					default: ;
				endcase
			end
			if (state_q == ST_LA_ADD) la_q <= sat32(trunc_fp(prod_s1) + gain_w);
			if (state_q == ST_NEW_WR) begin
				valid_q[slot_idx] <= 1'b1;
				ready_q[slot_idx] <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx;
		idx_s2 <= idx_s1;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					cmd_q <= req.cmd;
					slot_q <= req.thread_slot;
					idle_q <= req.running_idle;
					nice_q <= nice_in;
					parent_q <= req.parent_slot;
					flag_q <= req.flag_value;
					yld_q <= 1'b0;
				end
			end
			ST_DISP: begin
				sec_hit_q <= sec_hit_d;
				qtr_hit_q <= qtr_hit_d;
				rcnt_q <= idle_q ? '0 : RW'(1);
				if (cmd_q == CMD_TICK) yld_q <= 32'(slc_next) >= 32'(SLICE_TICKS);
			end
			ST_CNT: begin
				if (valid_q[scan_idx] && ready_q[scan_idx]) rcnt_q <= rcnt_q + RW'(1);
			end
			ST_DIV_WAIT: begin
				if (div_st.done) coef_q <= div_quo[COEF_W-1:0];
			end
			ST_RC_SCAN: nice_s2 <= rd_nice_q;
			ST_PRI_SCAN: run_pri_q <= '0;
			ST_RUN_GET: run_pri_q <= rd_pri_q;
			ST_OUT_SCAN: begin
				if (cnt_q >= CW'(1) && valid_q[idx_s1] && ready_q[idx_s1]
					&& rd_pri_q > run_pri_q) yld_q <= 1'b1;
			end
			ST_NICE_WR: run_pri_q <= wd_pri;
			ST_REP_GET: res_pri_q <= slot_in ? rd_pri_q : '0;
			ST_REP_RC: res_rc_q <= 26'(la_r);
			ST_REP_LA: begin
				if (la_r < 48'sd0) res_la_q <= '0;
				else if (la_r > 48'(LA_X100_MAX)) res_la_q <= 13'(LA_X100_MAX);
				else res_la_q <= 13'(la_r);
			end
			ST_DONE: begin
				if (out_free) begin
					out_yield_q <= yld_q;
					out_pri_q <= pri_w[5:0];
					out_rc_q <= res_rc_q;
					out_la_q <= res_la_q;
				end
			end
			default: ;
		endcase
	end

	assign pri_w = (PW + 6)'(res_pri_q);

	assign req.ready = state_q == ST_IDLE;
	assign rsp.valid = rsp_valid_q;
	assign rsp.yield_now = out_yield_q;
	assign rsp.slot_priority = out_pri_q;
	assign rsp.recent_cpu_x100 = out_rc_q;
	assign rsp.load_avg_x100 = out_la_q;

	`MLFQS_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	`MLFQS_ASSERT_IMP(a_div_done_in_wait, clk, arst_n, div_st.done, state_q == ST_DIV_WAIT)
	`MLFQS_ASSERT_IMP(a_load_nonneg, clk, arst_n, 1'b1, !la_q[31])
	`MLFQS_ASSERT_NXT(a_done_holds, clk, arst_n, state_q == ST_DONE && rsp.valid && !rsp.ready, state_q == ST_DONE && rsp.valid)

endmodule
